// File: design/trsa_pkg.sv
package trsa_pkg;

  // Action codes carried in the request.
  localparam logic [1:0] ACT_PUBLISH = 2'd0;
  localparam logic [1:0] ACT_GET     = 2'd1;
  localparam logic [1:0] ACT_CLEANUP = 2'd2;

  // Status codes returned in the result.
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_NONE    = 3'd2;
  localparam logic [2:0] ST_EXACT   = 3'd3;
  localparam logic [2:0] ST_LATER   = 3'd4;
  localparam logic [2:0] ST_CLEANED = 3'd5;

  localparam logic [15:0] AGE_LIMIT_RESET = 16'd4;
  localparam logic [31:0] FIRST_NUMBER    = 32'd1;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  topic;
    logic [31:0] last_entry;
    logic [31:0] payload;
    logic [31:0] now_seconds;
  } req_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_id;
    logic [31:0] found_payload;
    logic [4:0]  removed_count;
  } rsp_t;

  // One stored ring slot.
  typedef struct packed {
    logic [31:0] number;
    logic [31:0] stamp;
    logic [31:0] payload;
  } slot_t;

  // Flags produced by the shared compare unit.
  typedef struct packed {
    logic ge;
    logic eq;
    logic old;
  } eval_t;

endpackage

// File: design/trsa_slot_ram.sv
module trsa_slot_ram
  import trsa_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
  input  slot_t                       wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
  output slot_t                       rd_data
);

  slot_t mem [ENTRIES];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Single registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/trsa_eval_unit.sv
module trsa_eval_unit
  import trsa_pkg::*;
(
  input  slot_t        slot,
  input  logic [31:0]  target,
  input  logic [31:0]  now_seconds,
  input  logic [15:0]  age_limit,
  output eval_t        flags
);

  logic [31:0] age;

  // Age of the slot; a stamp in the future is never old.
  assign age = now_seconds - slot.stamp;

  // Number match against the search target and age check against the limit.
  always_comb begin
    flags.ge  = slot.number >= target;
    flags.eq  = slot.number == target;
    flags.old = (now_seconds >= slot.stamp) && (age >= {16'd0, age_limit});
  end

endmodule

// File: design/topic_ring_store_with_aging.sv
// Topic ring store with aging. Each request names a topic ring and an action:
// publish appends a payload with the ring's next entry number and the given
// time, get returns the oldest live entry numbered at least last_entry + 1,
// and cleanup pops the oldest entries whose age has reached age_limit. One
// request is handled at a time and the request channel stalls meanwhile; a
// finished result may wait in the output register while the next request is
// taken. A publish or any request that needs no search goes from the load step
// straight to the finishing step, which loads the result register; the block
// then returns to idle. A get or cleanup that needs a search walks the live
// entries of its ring between those two steps; the slot memory delivers one
// entry per cycle through its single registered read port into one shared
// compare unit. While an earlier result is still held on the output, the
// finishing step waits. The age limit register may be written at any time the
// block is idle; after reset no clearing pass is needed.
module topic_ring_store_with_aging
  import trsa_pkg::*;
#(
  parameter int RING_DEPTH  = 16,
  parameter int TOPIC_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int TOPIC_W = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
  localparam int ENTRIES = TOPIC_COUNT * RING_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  // Per-topic ring bookkeeping.
  logic [PTR_W-1:0] write_index [TOPIC_COUNT];
  logic [PTR_W-1:0] read_index  [TOPIC_COUNT];
  logic [CNT_W-1:0] fill_count  [TOPIC_COUNT];
  logic [31:0]      next_number [TOPIC_COUNT];

  logic [15:0]        age_limit;
  req_t               cur;
  rsp_t               res;
  logic [ADDR_W-1:0]  base;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   issue_k;
  logic [CNT_W-1:0]   rd_k;
  logic               rd_vld;
  logic [CNT_W-1:0]   removed;
  logic [31:0]        target;

  logic [TOPIC_W-1:0] tidx;
  logic               topic_ok;
  logic [ADDR_W-1:0]  topic_base;
  logic [PTR_W:0]     pos_sum;
  logic [PTR_W-1:0]   pos;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  slot_t              wr_data;
  slot_t              rd_data;
  eval_t              ev;
  logic               last_check;
  logic [CNT_W-1:0]   rm_final;
  logic [PTR_W:0]     rp_sum;
  logic [PTR_W-1:0]   rp_new;
  logic [PTR_W-1:0]   wi_next;
  logic               can_store;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Topic decode for the request being worked on.
  assign tidx       = TOPIC_W'(cur.topic);
  assign topic_ok   = 32'(cur.topic) < TOPIC_COUNT;
  assign topic_base = ADDR_W'(32'(tidx) * RING_DEPTH);

  // Publish path: one slot write during the load step.
  always_comb begin
    can_store = topic_ok && (fill_count[tidx] < CNT_W'(RING_DEPTH));
    wr_en     = (state == S_LOAD) && (cur.action == ACT_PUBLISH) && can_store;
    wr_addr   = topic_base + ADDR_W'(write_index[tidx]);
    wr_data.number  = next_number[tidx];
    wr_data.stamp   = cur.now_seconds;
    wr_data.payload = cur.payload;
    if (write_index[tidx] == PTR_W'(RING_DEPTH - 1)) begin
      wi_next = '0;
    end else begin
      wi_next = write_index[tidx] + PTR_W'(1);
    end
  end

  // Walk address: ring position of the next entry to fetch, wrapped.
  always_comb begin
    pos_sum = {1'b0, rd_ptr} + (PTR_W+1)'(issue_k);
    if (pos_sum >= (PTR_W+1)'(RING_DEPTH)) begin
      pos = PTR_W'(pos_sum - (PTR_W+1)'(RING_DEPTH));
    end else begin
      pos = PTR_W'(pos_sum);
    end
    rd_en   = (state == S_WALK) && (issue_k < cnt);
    rd_addr = base + ADDR_W'(pos);
  end

  // Cleanup commit: how many entries go and where the ring now starts.
  always_comb begin
    last_check = (rd_k + CNT_W'(1)) == cnt;
    rm_final   = ev.old ? (removed + CNT_W'(1)) : removed;
    rp_sum     = {1'b0, rd_ptr} + (PTR_W+1)'(rm_final);
    if (rp_sum >= (PTR_W+1)'(RING_DEPTH)) begin
      rp_new = PTR_W'(rp_sum - (PTR_W+1)'(RING_DEPTH));
    end else begin
      rp_new = PTR_W'(rp_sum);
    end
  end

  trsa_slot_ram #(
    .ENTRIES (ENTRIES)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  trsa_eval_unit u_eval_unit (
    .slot        (rd_data),
    .target      (target),
    .now_seconds (cur.now_seconds),
    .age_limit   (age_limit),
    .flags       (ev)
  );

  // Sequencer, ring bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_vld    <= 1'b0;
      age_limit <= AGE_LIMIT_RESET;
      for (int t = 0; t < TOPIC_COUNT; t++) begin
        write_index[t] <= '0;
        read_index[t]  <= '0;
        fill_count[t]  <= '0;
        next_number[t] <= FIRST_NUMBER;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        age_limit <= cfg_data;
      end

      // The output register is loaded from the finishing step or emptied when taken.
      if ((state == S_FINISH) && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      rd_vld <= rd_en;
      rd_k   <= issue_k;

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_LOAD;
          end
        end

        S_LOAD: begin
          rd_ptr  <= read_index[tidx];
          cnt     <= fill_count[tidx];
          base    <= topic_base;
          issue_k <= '0;
          removed <= '0;
          target  <= cur.last_entry + 32'd1;
          res.found_payload <= '0;
          res.removed_count <= '0;
          unique case (cur.action)
            ACT_PUBLISH: begin
              state <= S_FINISH;
              if (can_store) begin
                res.status   <= ST_STORED;
                res.entry_id <= next_number[tidx];
                next_number[tidx] <= next_number[tidx] + 32'd1;
                write_index[tidx] <= wi_next;
                fill_count[tidx]  <= fill_count[tidx] + CNT_W'(1);
              end else begin
                res.status   <= ST_FULL;
                res.entry_id <= '0;
              end
            end
            ACT_GET: begin
              res.status   <= ST_NONE;
              res.entry_id <= '0;
              if (topic_ok && (fill_count[tidx] != '0)) begin
                state <= S_WALK;
              end else begin
                state <= S_FINISH;
              end
            end
            ACT_CLEANUP: begin
              res.status   <= ST_CLEANED;
              res.entry_id <= '0;
              if (topic_ok && (fill_count[tidx] != '0)) begin
                state <= S_WALK;
              end else begin
                state <= S_FINISH;
              end
            end
            default: begin
              res.status   <= ST_NONE;
              res.entry_id <= '0;
              state        <= S_FINISH;
            end
          endcase
        end

        S_WALK: begin
          if (rd_en) begin
            issue_k <= issue_k + CNT_W'(1);
          end
          if (rd_vld) begin
            if (cur.action == ACT_GET) begin
              // Stop at the first entry at or beyond the target.
              if (ev.ge) begin
                res.status        <= ev.eq ? ST_EXACT : ST_LATER;
                res.entry_id      <= rd_data.number;
                res.found_payload <= rd_data.payload;
                state             <= S_FINISH;
              end else if (last_check) begin
                state <= S_FINISH;
              end
            end else begin
              // Pop old entries until a young one or an empty ring.
              removed <= rm_final;
              if (!ev.old || last_check) begin
                res.removed_count <= 5'(rm_final);
                read_index[tidx]  <= rp_new;
                fill_count[tidx]  <= cnt - rm_final;
                state             <= S_FINISH;
              end
            end
          end
        end

        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A returned entry fetch always belongs to a live entry of the ring.
  assert property (@(posedge clk) disable iff (rst)
    (rd_vld && (state == S_WALK)) |-> (rd_k < cnt))
    else $error("slot fetch beyond live entries");

  // A new result only appears from the finishing step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside finish step");

  // Slot writes happen only for a publish in the load step.
  assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == S_FINISH) && (res.status == ST_STORED))
    else $error("slot write without stored result");

  // Ring bookkeeping stays consistent for every topic.
  for (genvar g = 0; g < TOPIC_COUNT; g++) begin : g_ring_chk
    assert property (@(posedge clk) disable iff (rst)
      (fill_count[g] <= CNT_W'(RING_DEPTH)) &&
      (((32'(read_index[g]) + 32'(fill_count[g])) % RING_DEPTH) ==
       32'(write_index[g])))
      else $error("ring pointers and fill count disagree");
  end

endmodule
